FILE: rtl/itdt_pkg.sv
`default_nettype none

package itdt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;

  // decimal digits needed for 2^VALUE_WIDTH, floor(w * 0.3) + 1 holds for 8..64
  localparam int MAX_DIGITS  = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CHAR_W = 8;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // shift-add-3 correction for a bcd digit before each shift
  localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ       = 4'd3;

  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/itdt_front.sv
`default_nettype none

module itdt_front
  import itdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,   // [VALUE_WIDTH-1:0] value
  output logic                       item_valid,
  input  wire logic                  item_ready,
  output item_t                      item
);

  logic                   valid_r;
  logic                   valid_nxt;
  item_t                  item_r;
  logic [VALUE_WIDTH-1:0] value;
  logic                   accept;

  assign value     = in_tdata[VALUE_WIDTH-1:0];
  assign in_tready = !valid_r || item_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // magnitude in unsigned bits, so the most negative value stays exact
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.neg <= value[VALUE_WIDTH-1];
      item_r.mag <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

FILE: rtl/itdt_queue.sv
`default_nettype none

module itdt_queue
  import itdt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  wire item_t wr_item,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output item_t      rd_item
);

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              push;
  logic              pop;

  assign wr_ready = cnt_r != QCNT_W'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/itdt_back.sv
`default_nettype none

module itdt_back
  import itdt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire item_t             item,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [CHAR_W-1:0]      out_tdata,   // [7:0] text_char
  output logic                   out_tlast    // last_char
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_COUNT = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0]                  state_r;
  logic [2:0]                  state_nxt;
  logic                        neg_r;
  logic [VALUE_WIDTH-1:0]      shift_r;
  logic [VALUE_WIDTH-1:0]      shift_nxt;
  logic [MAX_DIGITS-1:0][3:0]  bcd_r;
  logic [MAX_DIGITS-1:0][3:0]  bcd_nxt;
  logic [MAX_DIGITS-1:0][3:0]  bcd_adj;
  logic [BIT_CNT_W-1:0]        bit_cnt_r;
  logic [BIT_CNT_W-1:0]        bit_cnt_nxt;
  logic [DIGIT_IDX_W-1:0]      idx_r;
  logic [DIGIT_IDX_W-1:0]      idx_nxt;
  logic [DIGIT_IDX_W-1:0]      top_idx;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [CHAR_W-1:0]           out_char_r;
  logic                        out_last_r;
  logic                        slot_free;
  logic                        load_out;
  logic [CHAR_W-1:0]           load_char;
  logic                        load_last;

  assign slot_free  = !out_valid_r || out_tready;
  assign item_ready = state_r == ST_IDLE;

  // double dabble: add 3 to digits of 5 and up, then shift one bit in
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= BCD_ADJ_LIMIT) ? bcd_r[i] + BCD_ADJ : bcd_r[i];
    end
  end

  // most significant nonzero digit, digit zero when all are zero
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        top_idx = DIGIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    shift_nxt   = shift_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    idx_nxt     = idx_r;
    load_out    = 1'b0;
    load_char   = CHAR_MINUS;
    load_last   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          shift_nxt   = item.mag;
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (i == 0) begin
            bcd_nxt[i] = {bcd_adj[i][2:0], shift_r[VALUE_WIDTH-1]};
          end else begin
            bcd_nxt[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
          end
        end
        shift_nxt   = {shift_r[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        idx_nxt   = top_idx;
        state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (slot_free) begin
          load_out  = 1'b1;
          load_char = CHAR_MINUS;
          load_last = 1'b0;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          load_out  = 1'b1;
          load_char = CHAR_ZERO + {4'd0, bcd_r[idx_r]};
          load_last = idx_r == '0;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r   <= shift_nxt;
    bcd_r     <= bcd_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    idx_r     <= idx_nxt;
    if (state_r == ST_IDLE && item_valid) begin
      neg_r <= item.neg;
    end
    if (load_out) begin
      out_char_r <= load_char;
      out_last_r <= load_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  a_conv_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && bit_cnt_r != BIT_CNT_W'(VALUE_WIDTH - 1)) |=> state_r == ST_CONV)
    else $error("conversion left before all magnitude bits were shifted");

  a_digit_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT && slot_free && idx_r != '0)
      |=> (state_r == ST_DIGIT && idx_r == $past(idx_r) - 1'b1))
    else $error("digit index did not step down by one");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == CHAR_MINUS ||
                     (out_char_r >= CHAR_ZERO && out_char_r <= CHAR_ZERO + 8'd9)))
    else $error("output word is neither a digit nor a minus sign");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == CHAR_MINUS) |-> !out_last_r)
    else $error("minus sign marked as last character");

endmodule

`default_nettype wire

FILE: rtl/integer_to_decimal_text_unit.sv
// channel  direction  handshake                  tdata                tuser/tlast
// in_      slave      in_tvalid / in_tready      value [31:0] signed  -
// out_     master     out_tvalid / out_tready    text_char [7:0]      tlast = last_char
//
// the back end converts each number in the shift-add-3 loop, one magnitude bit a
// cycle, then emits its characters, most significant digit first.
// reset is synchronous and active low; no memory clearing is needed after it.
// a stalled output holds the emitter; the input register and a two-entry queue
// keep taking numbers while the back end is busy.
`default_nettype none

module integer_to_decimal_text_unit
  import itdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,   // [VALUE_WIDTH-1:0] value
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [CHAR_W-1:0]          out_tdata,  // [7:0] text_char
  output logic                       out_tlast   // last_char
);

  logic  fr_valid;
  logic  fr_ready;
  item_t fr_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  itdt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item       (fr_item)
  );

  itdt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_item  (fr_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  itdt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none

module testbench;
  import itdt_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // expected characters for every accepted number, oldest first
  class text_scoreboard;
    text_char_t pending_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function void note_value(logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] mag;
      logic [3:0]             digits[$];
      text_char_t             c;
      mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      do begin
        digits.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (value[VALUE_WIDTH-1]) begin
        c.ch   = CHAR_MINUS;
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      foreach (digits[i]) begin
        c.ch   = CHAR_ZERO + CHAR_W'(digits[i]);
        c.last = (i == digits.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t unexpected word: text_char %h last_char %b", $time, ch, last);
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch) begin
        errors++;
        $display("%0t text_char mismatch: expected %h actual %h", $time, want.ch, ch);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t last_char mismatch: expected %b actual %b", $time, want.last, last);
      end
    endfunction

    function int waiting();
      return pending_chars.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [CHAR_W-1:0]     out_tdata;
  logic                  out_tlast;

  text_scoreboard sb;
  int  snd_idle_pct = 0;
  int  rcv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  integer_to_decimal_text_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_value(in_tdata[VALUE_WIDTH-1:0]);
      if (out_tvalid && out_tready) sb.check_char(out_tdata, out_tlast);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(value);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // mix of full-range words, short magnitudes of every length and values near the ends
  function automatic logic [VALUE_WIDTH-1:0] rand_value();
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] span;
    int                     ndig;
    case ($urandom_range(3))
      0, 1: v = $urandom;
      2: begin
        ndig = $urandom_range(1, 9);
        span = 1;
        repeat (ndig) span = span * 10;
        v = $urandom % span;
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
      default: begin
        if ($urandom_range(1)) v = {1'b1, {(VALUE_WIDTH-1){1'b0}}} + $urandom_range(5);
        else v = {1'b0, {(VALUE_WIDTH-1){1'b1}}} - $urandom_range(5);
      end
    endcase
    return v;
  endfunction

  task automatic run_phase(input int count, input int snd_pct, input int rcv_pct);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    repeat (count) send_value(rand_value());
  endtask

  initial begin
    logic [VALUE_WIDTH-1:0] directed[$];
    sb = new();
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, 32'd12345, -32'sd5, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'd1000, -32'sd100000, 32'd4294, 32'h0000_FFFF};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_value(directed[i]);
    run_phase(49, 0, 0);
    run_phase(49, 87, 0);
    run_phase(49, 0, 87);
    run_phase(49, 28, 28);

    // input must back up while the output is held off
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_req      = 1'b1;
    repeat (12) send_value(rand_value());
    in_tvalid <= 1'b0;

    while (sb.waiting() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/itdt_pkg.sv
rtl/itdt_front.sv
rtl/itdt_queue.sv
rtl/itdt_back.sv
rtl/integer_to_decimal_text_unit.sv
tb/sv/testbench.sv
